>>> src/cdq_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque package
// Shared widths, reset values and action codes for the deque block.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  // Width of one stored value and of the front and back result values.
  localparam int unsigned DataW = 32;

  // Width of the capacity register and of the entry count.
  localparam int unsigned CfgW = 5;

  // Width of the action code.
  localparam int unsigned ActW = 3;

  // Capacity after reset.
  localparam logic [CfgW-1:0] CapReset = 5'd16;

  // Value reported at the front and back of an empty deque.
  localparam logic [DataW-1:0] EmptyValue = '1;

  // Action codes; the codes above the no-operation code act as no-operation.
  typedef enum logic [ActW-1:0] {
    ActPushFront = 3'd0,
    ActPushBack  = 3'd1,
    ActPopFront  = 3'd2,
    ActPopBack   = 3'd3,
    ActNop       = 3'd4
  } action_e;

endpackage

`default_nettype wire

>>> src/cdq_ring_mem.sv
// ----------------------------------------------------------------------------
// Circular deque ring memory
// Ring store with one write port and two registered read ports, one for the
// front entry and one for the back entry.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ring_mem
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IW-1:0]    waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic [IW-1:0]    front_addr_i,
  input  wire logic [IW-1:0]    back_addr_i,
  output logic      [DataW-1:0] front_data_o,
  output logic      [DataW-1:0] back_data_o
);

  logic [DataW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    front_data_o <= mem[front_addr_i];
    back_data_o  <= mem[back_addr_i];
  end

endmodule

`default_nettype wire

>>> src/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// Circular deque control
// Holds the capacity register, head and tail indices and the entry count,
// writes pushed values into the ring memory and sequences the read of the
// front and back entries for each result.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Command side
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [ActW-1:0]  action_i,
  input  wire logic [DataW-1:0] item_value_i,
  // Configuration side
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CfgW-1:0]  cfg_data_i,
  // Ring memory side
  output logic                  mem_we_o,
  output logic      [IW-1:0]    mem_waddr_o,
  output logic      [DataW-1:0] mem_wdata_o,
  output logic      [IW-1:0]    front_addr_o,
  output logic      [IW-1:0]    back_addr_o,
  // Result side
  output logic                  done_o,
  output logic                  accepted_o,
  output logic                  is_empty_o,
  output logic                  is_full_o
);

  localparam int unsigned CmpW = ((IW > CfgW) ? IW : CfgW) + 1;
  localparam logic [31:0] DepthU = 32'(DEPTH);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StResp
  } state_e;

  state_e          state_q;
  logic [CfgW-1:0] cap_q;
  logic [IW-1:0]   head_q, head_d;
  logic [IW-1:0]   tail_q, tail_d;
  logic [CfgW-1:0] count_q, count_d;
  logic            acc_q, acc_d;
  logic [CfgW-1:0] cap;
  logic [IW-1:0]   cap_m1;
  logic            full;
  logic            empty;
  logic            take;
  logic            cfg_write;

  // Step an index forward, wrapping at the capacity in use.
  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i,
                                            input logic [CfgW-1:0] c);
    logic [CmpW-1:0] nxt;
    nxt = CmpW'(i) + CmpW'(1);
    return (nxt >= CmpW'(c)) ? '0 : IW'(nxt);
  endfunction

  // Step an index back, wrapping to the last slot in use.
  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i,
                                            input logic [IW-1:0] last);
    return (i == '0) ? last : i - IW'(1);
  endfunction

  // Effective capacity, clamped to one up to the ring depth.
  always_comb begin
    if (cap_q == '0) begin
      cap = CfgW'(1);
    end else if (32'(cap_q) > DepthU) begin
      cap = CfgW'(DEPTH);
    end else begin
      cap = cap_q;
    end
  end

  assign cap_m1    = IW'(cap - CfgW'(1));
  assign full      = (count_q >= cap);
  assign empty     = (count_q == '0);
  assign busy      = (state_q != StIdle);
  assign take      = start && !busy;
  // The capacity is only written while idle and no command is offered.
  assign cfg_ready_o = !busy && !start;
  assign cfg_write = cfg_valid_i && cfg_ready_o;

  // Decode the action and work out the next indices, count and store write.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    acc_d       = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = item_value_i;
    unique case (action_i)
      ActPushFront: begin
        if (!full) begin
          head_d      = idx_dec(head_q, cap_m1);
          mem_waddr_o = head_d;
          mem_we_o    = take;
          count_d     = count_q + CfgW'(1);
          acc_d       = 1'b1;
        end
      end
      ActPushBack: begin
        if (!full) begin
          mem_waddr_o = tail_q;
          mem_we_o    = take;
          tail_d      = idx_inc(tail_q, cap);
          count_d     = count_q + CfgW'(1);
          acc_d       = 1'b1;
        end
      end
      ActPopFront: begin
        if (!empty) begin
          head_d  = idx_inc(head_q, cap);
          count_d = count_q - CfgW'(1);
          acc_d   = 1'b1;
        end
      end
      ActPopBack: begin
        if (!empty) begin
          tail_d  = idx_dec(tail_q, cap_m1);
          count_d = count_q - CfgW'(1);
          acc_d   = 1'b1;
        end
      end
      default: begin
        acc_d = 1'b0;
      end
    endcase
  end

  // Read addresses of the front entry and of the entry before the tail.
  assign front_addr_o = head_q;
  assign back_addr_o  = idx_dec(tail_q, cap_m1);

  // State, indices, count, capacity and the registered accept flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q   <= CapReset;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      acc_q   <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cfg_write) begin
            cap_q   <= cfg_data_i;
            head_q  <= '0;
            tail_q  <= '0;
            count_q <= '0;
          end else if (take) begin
            state_q <= StRead;
            head_q  <= head_d;
            tail_q  <= tail_d;
            count_q <= count_d;
            acc_q   <= acc_d;
          end
        end
        StRead: begin
          state_q <= StResp;
        end
        StResp: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign done_o     = (state_q == StResp);
  assign accepted_o = acc_q;
  assign is_empty_o = empty;
  assign is_full_o  = (count_q == cap);

endmodule

`default_nettype wire

>>> src/circular_deque_top.sv
// A taken command runs via StRead to StResp, where done_o strobes the result beat.
// No new command is taken while busy; a taken command writes the ring memory,
// the next cycle reads the front and back entries through its registered read ports.
// busy is high from the cycle after the command until the result beat has been shown.
// Reset clears the indices and the count and sets the capacity to 16; memory is kept.
// ----------------------------------------------------------------------------
// Circular deque top level
// Double-ended queue in a ring memory with a programmable capacity in use.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Command channel
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [ActW-1:0]  action_i,
  input  wire logic [DataW-1:0] item_value_i,
  // Configuration channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CfgW-1:0]  cfg_data_i,
  // Result channel
  output logic                  done_o,
  output logic                  accepted_o,
  output logic      [DataW-1:0] front_value_o,
  output logic      [DataW-1:0] back_value_o,
  output logic                  is_empty_o,
  output logic                  is_full_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [IW-1:0]    front_addr;
  logic [IW-1:0]    back_addr;
  logic [DataW-1:0] front_data;
  logic [DataW-1:0] back_data;
  logic             empty;

  cdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .item_value_i (item_value_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .front_addr_o (front_addr),
    .back_addr_o  (back_addr),
    .done_o       (done_o),
    .accepted_o   (accepted_o),
    .is_empty_o   (empty),
    .is_full_o    (is_full_o)
  );

  cdq_ring_mem #(
    .DEPTH(DEPTH)
  ) u_ring_mem (
    .clk_i        (clk_i),
    .we_i         (mem_we),
    .waddr_i      (mem_waddr),
    .wdata_i      (mem_wdata),
    .front_addr_i (front_addr),
    .back_addr_i  (back_addr),
    .front_data_o (front_data),
    .back_data_o  (back_data)
  );

  // An empty deque reports minus one at both ends.
  assign is_empty_o    = empty;
  assign front_value_o = empty ? EmptyValue : front_data;
  assign back_value_o  = empty ? EmptyValue : back_data;

endmodule

`default_nettype wire

>>> src/cdq_checker.sv
// ----------------------------------------------------------------------------
// Circular deque port checker
// Watches the top-level ports for command, result and flag consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_port_assert
  import cdq_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [ActW-1:0]  action_i,
  input wire logic             done_o,
  input wire logic             accepted_o,
  input wire logic [DataW-1:0] front_value_o,
  input wire logic [DataW-1:0] back_value_o,
  input wire logic             is_empty_o,
  input wire logic             is_full_o
);

  // Every taken command produces its result beat.
  a_cmd_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result beat missing after command");

  // A result beat lasts one cycle and never overlaps a new command.
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy ##1 !done_o))
    else $error("result beat not a single busy cycle");

  // A no-operation or unknown action is never reported as carried out.
  a_nop_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i != ActPushFront && action_i != ActPushBack
     && action_i != ActPopFront && action_i != ActPopBack)
    |-> ##2 (done_o && !accepted_o))
    else $error("no-operation reported as accepted");

  // An empty deque shows minus one at both ends and cannot be full.
  a_empty_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |->
      (front_value_o == EmptyValue && back_value_o == EmptyValue && !is_full_o))
    else $error("empty deque shows stored values or full flag");

endmodule

bind circular_deque_top cdq_port_assert u_cdq_port_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .action_i      (action_i),
  .done_o        (done_o),
  .accepted_o    (accepted_o),
  .front_value_o (front_value_o),
  .back_value_o  (back_value_o),
  .is_empty_o    (is_empty_o),
  .is_full_o     (is_full_o)
);

`default_nettype wire
